// ----- design/slmf_pkg.sv -----
package slmf_pkg;

  // sizes of the link frames
  localparam int HEADER_BYTES       = 3;
  localparam int MAX_PROCESS_BYTES  = 16;
  localparam int FRAME_BUFFER_BYTES = 64;

  localparam int MIN_FRAME_BYTES      = HEADER_BYTES + 2;
  localparam int SESSION_FRAME_BYTES  = HEADER_BYTES + 4;
  localparam int CONNECT_FRAME_BYTES  = HEADER_BYTES + 10;
  localparam int FAILSAFE_FRAME_BYTES = HEADER_BYTES + MAX_PROCESS_BYTES + 2;

  // command codes
  localparam logic [2:0] CMD_FRAME    = 3'd0;
  localparam logic [2:0] CMD_TIME     = 3'd1;
  localparam logic [2:0] CMD_RESET    = 3'd2;
  localparam logic [2:0] CMD_CLEAR    = 3'd3;
  localparam logic [2:0] CMD_TRANSMIT = 3'd4;

  // received frame types
  localparam logic [2:0] FT_PDATA      = 3'd0;
  localparam logic [2:0] FT_SESSION    = 3'd1;
  localparam logic [2:0] FT_CONNECTION = 3'd2;
  localparam logic [2:0] FT_PARAM      = 3'd3;

  // reported link states
  localparam logic [2:0] LS_RESET      = 3'd0;
  localparam logic [2:0] LS_SESSION    = 3'd1;
  localparam logic [2:0] LS_CONNECTION = 3'd2;
  localparam logic [2:0] LS_PARAMETER  = 3'd3;
  localparam logic [2:0] LS_DATA       = 3'd4;
  localparam logic [2:0] LS_FAILSAFE   = 3'd5;

  // fault codes
  localparam logic [2:0] FLT_NONE     = 3'd0;
  localparam logic [2:0] FLT_CRC      = 3'd1;
  localparam logic [2:0] FLT_ID       = 3'd2;
  localparam logic [2:0] FLT_SEQ      = 3'd3;
  localparam logic [2:0] FLT_WATCHDOG = 3'd4;

  // transmit frame kinds
  localparam logic [2:0] TX_NONE     = 3'd0;
  localparam logic [2:0] TX_SESSION  = 3'd1;
  localparam logic [2:0] TX_CONNECT  = 3'd2;
  localparam logic [2:0] TX_DATA     = 3'd3;
  localparam logic [2:0] TX_FAILSAFE = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_LINK_ID    = 2'd0;
  localparam logic [1:0] CFG_IN_BYTES   = 2'd1;
  localparam logic [1:0] CFG_OUT_BYTES  = 2'd2;
  localparam logic [1:0] CFG_TIMEOUT_MS = 2'd3;

  localparam logic [31:0] TIMEOUT_RESET = 32'd100;

  // link phase, one-hot
  typedef enum logic [5:0] {
    PH_RESET      = 6'b000001,
    PH_SESSION    = 6'b000010,
    PH_CONNECTION = 6'b000100,
    PH_PARAMETER  = 6'b001000,
    PH_DATA       = 6'b010000,
    PH_FAILSAFE   = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [2:0]  frame_type;
    logic [7:0]  id_low_byte;
    logic [7:0]  id_high_byte;
    logic [6:0]  frame_len;
    logic        crc_ok;
    logic [31:0] now_ms;
  } slmf_in_t;

  typedef struct packed {
    logic        accepted;
    logic [2:0]  link_state;
    logic [2:0]  fault_code;
    logic        fail_safe;
    logic        safe_in_valid;
    logic        capture_payload;
    logic [2:0]  tx_kind;
    logic [3:0]  tx_seq_nibble;
    logic [15:0] session_number;
    logic [31:0] watchdog_elapsed;
  } slmf_out_t;

  // one-hot phase to reported state code
  function automatic logic [2:0] phase_code(phase_t ph);
    logic [2:0] code;
    unique case (ph)
      PH_RESET:      code = LS_RESET;
      PH_SESSION:    code = LS_SESSION;
      PH_CONNECTION: code = LS_CONNECTION;
      PH_PARAMETER:  code = LS_PARAMETER;
      PH_DATA:       code = LS_DATA;
      PH_FAILSAFE:   code = LS_FAILSAFE;
      default:       code = LS_RESET;
    endcase
    return code;
  endfunction

endpackage

// ----- design/slmf_core.sv -----
module slmf_core
  import slmf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        step,
  input  slmf_in_t    item,
  output slmf_out_t   res
);

  logic [15:0] link_id_r;
  logic [4:0]  in_bytes_r;
  logic [4:0]  out_bytes_r;
  logic [31:0] timeout_r;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  fault_r, fault_nxt;
  logic        safe_r, safe_nxt;
  logic        ivalid_r, ivalid_nxt;
  logic [3:0]  rx_seq_r, rx_seq_nxt;
  logic [3:0]  tx_seq_r, tx_seq_nxt;
  logic [15:0] session_r, session_nxt;
  logic [15:0] sent_r, sent_nxt;
  logic [31:0] last_good_r, last_good_nxt;
  logic [31:0] time_now_r, time_now_nxt;
  logic [31:0] elapsed_r, elapsed_nxt;

  logic        link_ready;
  logic        len_ok;
  logic        id_ok;
  logic        seq_ok;
  logic        payload_ok;
  logic [3:0]  seq;
  logic [31:0] elapsed;
  logic [6:0]  need;
  logic        raise;
  logic [2:0]  raise_code;
  logic        acc;
  logic        cap;
  logic [2:0]  kind;
  logic [3:0]  txn;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_id_r   <= '0;
      in_bytes_r  <= '0;
      out_bytes_r <= '0;
      timeout_r   <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LINK_ID:    link_id_r   <= cfg_data[15:0];
        CFG_IN_BYTES:   in_bytes_r  <= cfg_data[4:0];
        CFG_OUT_BYTES:  out_bytes_r <= cfg_data[4:0];
        CFG_TIMEOUT_MS: timeout_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // header checks
  assign link_ready = ({1'b0, in_bytes_r} <= 6'(MAX_PROCESS_BYTES)) &&
                      ({1'b0, out_bytes_r} <= 6'(MAX_PROCESS_BYTES));
  assign len_ok     = item.frame_len >= 7'(MIN_FRAME_BYTES);
  assign id_ok      = {item.id_high_byte[3:0], item.id_low_byte} == link_id_r[11:0];
  assign seq        = item.id_high_byte[7:4];
  assign seq_ok     = seq == (rx_seq_r + 4'd1);
  assign payload_ok = (item.frame_len - 7'(MIN_FRAME_BYTES)) >= {2'b00, in_bytes_r};
  assign elapsed    = item.now_ms - last_good_r;

  // next state and result for one request
  always_comb begin
    phase_nxt     = phase_r;
    fault_nxt     = fault_r;
    safe_nxt      = safe_r;
    ivalid_nxt    = ivalid_r;
    rx_seq_nxt    = rx_seq_r;
    tx_seq_nxt    = tx_seq_r;
    session_nxt   = session_r;
    sent_nxt      = sent_r;
    last_good_nxt = last_good_r;
    time_now_nxt  = time_now_r;
    elapsed_nxt   = elapsed_r;
    raise         = 1'b0;
    raise_code    = FLT_NONE;
    acc           = 1'b0;
    cap           = 1'b0;
    kind          = TX_NONE;
    txn           = '0;
    need          = '0;

    if (link_ready) begin
      case (item.cmd) inside
        CMD_FRAME: begin
          if (len_ok) begin
            if (!item.crc_ok) begin
              raise      = 1'b1;
              raise_code = FLT_CRC;
            end else if (!id_ok) begin
              raise      = 1'b1;
              raise_code = FLT_ID;
            end else begin
              acc           = 1'b1;
              last_good_nxt = time_now_r;
              unique case (phase_r) inside
                PH_RESET: begin
                  session_nxt = (sent_r == '0) ? 16'd1 : sent_r;
                  phase_nxt   = PH_SESSION;
                end
                PH_SESSION: begin
                  if (item.frame_type == FT_SESSION) phase_nxt = PH_CONNECTION;
                end
                PH_CONNECTION: begin
                  if (item.frame_type == FT_CONNECTION || item.frame_type == FT_PARAM) begin
                    phase_nxt = (in_bytes_r != '0 || out_bytes_r != '0) ?
                                PH_PARAMETER : PH_DATA;
                  end
                end
                PH_PARAMETER, PH_DATA: begin
                  if (item.frame_type == FT_PARAM && phase_r == PH_PARAMETER) begin
                    phase_nxt = PH_DATA;
                  end else if (item.frame_type == FT_PDATA) begin
                    phase_nxt = PH_DATA;
                    // process data: sequence must be one above the last
                    if (!seq_ok) begin
                      raise      = 1'b1;
                      raise_code = FLT_SEQ;
                    end else begin
                      rx_seq_nxt = seq;
                      if (payload_ok) begin
                        ivalid_nxt = 1'b1;
                        cap        = 1'b1;
                      end
                    end
                  end
                end
                default: ;
              endcase
            end
          end
        end
        CMD_TIME: begin
          acc          = 1'b1;
          time_now_nxt = item.now_ms;
          if (phase_r == PH_DATA) begin
            elapsed_nxt = elapsed;
            if (elapsed > timeout_r) begin
              raise      = 1'b1;
              raise_code = FLT_WATCHDOG;
            end
          end
        end
        CMD_RESET, CMD_CLEAR: begin
          if (item.cmd == CMD_RESET || phase_r == PH_FAILSAFE) begin
            acc        = 1'b1;
            if (item.cmd == CMD_CLEAR) safe_nxt = 1'b0;
            phase_nxt  = PH_RESET;
            fault_nxt  = FLT_NONE;
            ivalid_nxt = 1'b0;
            rx_seq_nxt = 4'hF;
            tx_seq_nxt = '0;
          end
        end
        CMD_TRANSMIT: begin
          unique case (phase_r) inside
            PH_RESET, PH_SESSION: begin
              kind = TX_SESSION;
              need = 7'(SESSION_FRAME_BYTES);
            end
            PH_CONNECTION: begin
              kind = TX_CONNECT;
              need = 7'(CONNECT_FRAME_BYTES);
            end
            PH_PARAMETER, PH_DATA: begin
              kind = TX_DATA;
              need = 7'(MIN_FRAME_BYTES) + {2'b00, out_bytes_r};
            end
            default: begin
              kind = TX_FAILSAFE;
              need = 7'(FAILSAFE_FRAME_BYTES);
            end
          endcase
          if ({1'b0, need} > 8'(FRAME_BUFFER_BYTES)) begin
            kind = TX_NONE;
          end else begin
            acc      = 1'b1;
            if (kind == TX_DATA) txn = tx_seq_r;
            sent_nxt = sent_r + 16'd1;
            if (kind == TX_DATA || kind == TX_FAILSAFE) tx_seq_nxt = tx_seq_r + 4'd1;
          end
        end
        default: ;
      endcase
    end

    // fault latches fail-safe
    if (raise) begin
      fault_nxt  = raise_code;
      phase_nxt  = PH_FAILSAFE;
      safe_nxt   = 1'b1;
      ivalid_nxt = 1'b0;
    end
  end

  // link state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_RESET;
      fault_r     <= FLT_NONE;
      safe_r      <= 1'b0;
      ivalid_r    <= 1'b0;
      rx_seq_r    <= 4'hF;
      tx_seq_r    <= '0;
      session_r   <= '0;
      sent_r      <= '0;
      last_good_r <= '0;
      time_now_r  <= '0;
      elapsed_r   <= '0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      fault_r     <= fault_nxt;
      safe_r      <= safe_nxt;
      ivalid_r    <= ivalid_nxt;
      rx_seq_r    <= rx_seq_nxt;
      tx_seq_r    <= tx_seq_nxt;
      session_r   <= session_nxt;
      sent_r      <= sent_nxt;
      last_good_r <= last_good_nxt;
      time_now_r  <= time_now_nxt;
      elapsed_r   <= elapsed_nxt;
    end
  end

  // result shows the state after the request
  always_comb begin
    res.accepted         = acc;
    res.link_state       = phase_code(phase_nxt);
    res.fault_code       = fault_nxt;
    res.fail_safe        = safe_nxt;
    res.safe_in_valid    = ivalid_nxt;
    res.capture_payload  = cap;
    res.tx_kind          = kind;
    res.tx_seq_nibble    = txn;
    res.session_number   = session_nxt;
    res.watchdog_elapsed = elapsed_nxt;
  end

endmodule

// ----- design/safety_link_master_fsm_top.sv -----
// channel   direction  handshake           payload
// in_       request    in_valid/in_stall   slmf_in_t (command, header, time)
// out_      result     out_valid/out_stall slmf_out_t (state, flags, tx info)
// cfg_      write      cfg_we              cfg_index selects, cfg_data value
//
// a request is taken into the input register, worked through the link logic and
// lands in the result register when that is free or draining; one request per
// cycle sustained while out_stall is low
// synchronous active-low reset clears the link state and the config registers
// out_stall holds the result register; in_stall rises once the input register
// also holds a request and falls in the cycle the result drains
module safety_link_master_fsm_top
  import slmf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  slmf_in_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output slmf_out_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic      in_valid_r;
  slmf_in_t  in_item_r;
  logic      out_valid_r;
  slmf_out_t out_item_r;
  slmf_out_t res;
  logic      advance;

  // request moves into the result register when that is free or draining
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r <= in_data;
    end
  end

  slmf_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (advance),
    .item      (in_item_r),
    .res       (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule

// ----- design/slmf_chk.sv -----
module slmf_chk
  import slmf_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_stall,
  input slmf_out_t out_data
);

  // stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // fail-safe state is always latched with a fault code
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.link_state == LS_FAILSAFE |->
      out_data.fail_safe && out_data.fault_code != FLT_NONE)
    else $error("fail-safe state without latch or fault code");

  // safe inputs are only valid in the data state
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.safe_in_valid |-> out_data.link_state == LS_DATA)
    else $error("inputs valid outside data state");

  // capture strobe comes with valid inputs
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.capture_payload |-> out_data.safe_in_valid && out_data.accepted)
    else $error("payload capture without valid inputs");

endmodule

bind safety_link_master_fsm_top slmf_chk u_slmf_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
